[sv/pts_pkg.sv]
// Shared types and constants of the priority task scheduler.
package pts_pkg;

  localparam int unsigned MAX_TASKS = 8;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned TOTAL_W   = 4;
  localparam int unsigned PRIO_W    = 8;

  typedef enum logic [2:0] {
    REQ_CREATE   = 3'd0,
    REQ_DELAY    = 3'd1,
    REQ_SUSPEND  = 3'd2,
    REQ_ACTIVATE = 3'd3,
    REQ_TICK     = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_BAD_IDX  = 2'd2,
    STAT_NO_TASKS = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_READY     = 2'd0,
    MODE_RUNNING   = 2'd1,
    MODE_WAITING   = 2'd2,
    MODE_SUSPENDED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CELL_NOP,
    CELL_CREATE,
    CELL_WAIT,
    CELL_SUSPEND,
    CELL_READY,
    CELL_RUN,
    CELL_TICK
  } cell_op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LAUNCH,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [PRIO_W-1:0] new_priority;
    logic              auto_start;
    logic [31:0]       delay_ticks;
    logic [IDX_W-1:0]  target_task;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] new_handle;
    logic [IDX_W-1:0] running_task;
    logic             switched;
    logic [31:0]      tick_now;
  } res_t;

  typedef struct packed {
    cell_op_e           op;
    logic [IDX_W-1:0]   idx;
    logic [PRIO_W-1:0]  prio;
    logic               auto_start;
    logic [TOTAL_W-1:0] total;
  } cell_cmd_t;

  typedef struct packed {
    logic              go;
    logic [PRIO_W-1:0] best;
    logic [IDX_W-1:0]  pick;
  } chain_t;

endpackage

[sv/pts_cell.sv]
// One task entry of the scheduler chain with its stage of the dispatch search.
module pts_cell #(
  parameter int unsigned TICK_BITS = 32,
  parameter int unsigned CELL_IDX  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pts_pkg::cell_cmd_t        cmd_i,
  input  logic [TICK_BITS-1:0]      wait_i,
  input  pts_pkg::chain_t           chain_i,
  output pts_pkg::chain_t           chain_o
);

  pts_pkg::mode_e                 mode_q, mode_d;
  logic [pts_pkg::PRIO_W-1:0]     prio_q, prio_d;
  logic [TICK_BITS-1:0]           wait_q, wait_d;
  logic [TICK_BITS-1:0]           wait_dec;
  logic                           go_q;
  logic [pts_pkg::PRIO_W-1:0]     best_q, best_d;
  logic [pts_pkg::IDX_W-1:0]      pick_q, pick_d;
  logic                           hit;
  logic                           used;
  logic                           take;

  assign hit      = (cmd_i.idx == pts_pkg::IDX_W'(CELL_IDX));
  assign used     = (pts_pkg::TOTAL_W'(CELL_IDX) < cmd_i.total);
  assign wait_dec = wait_q - TICK_BITS'(1);

  always_comb begin
    mode_d = mode_q;
    prio_d = prio_q;
    wait_d = wait_q;
    unique case (cmd_i.op)
      pts_pkg::CELL_CREATE: begin
        if (hit) begin
          mode_d = cmd_i.auto_start ? pts_pkg::MODE_READY : pts_pkg::MODE_SUSPENDED;
          prio_d = cmd_i.prio;
          wait_d = '0;
        end
      end
      pts_pkg::CELL_WAIT: begin
        if (hit) begin
          mode_d = pts_pkg::MODE_WAITING;
          wait_d = wait_i;
        end
      end
      pts_pkg::CELL_SUSPEND: begin
        if (hit) mode_d = pts_pkg::MODE_SUSPENDED;
      end
      pts_pkg::CELL_READY: begin
        if (hit) mode_d = pts_pkg::MODE_READY;
      end
      pts_pkg::CELL_RUN: begin
        if (hit) mode_d = pts_pkg::MODE_RUNNING;
      end
      pts_pkg::CELL_TICK: begin
        if (used && mode_q == pts_pkg::MODE_WAITING) begin
          wait_d = wait_dec;
          if (wait_dec == '0) mode_d = pts_pkg::MODE_READY;
        end
      end
      default: begin
      end
    endcase
  end

  // Strictly greater keeps an earlier cell on equal priority.
  assign take = used && (mode_q == pts_pkg::MODE_READY || mode_q == pts_pkg::MODE_RUNNING)
                && (prio_q > chain_i.best);

  always_comb begin
    best_d = take ? prio_q : chain_i.best;
    pick_d = take ? pts_pkg::IDX_W'(CELL_IDX) : chain_i.pick;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= chain_i.go;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    prio_q <= prio_d;
    wait_q <= wait_d;
    best_q <= best_d;
    pick_q <= pick_d;
  end

  assign chain_o = '{go: go_q, best: best_q, pick: pick_q};

endmodule

[sv/pts_ctrl.sv]
// Request sequencer: applies an item to the cells, runs the dispatch sweep, returns the result.
module pts_ctrl #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pts_pkg::req_t        req_i,
  output logic                 done_o,
  output pts_pkg::res_t        res_o,
  output pts_pkg::cell_cmd_t   cmd_o,
  output logic [TICK_BITS-1:0] wait_o,
  output pts_pkg::chain_t      chain_o,
  input  pts_pkg::chain_t      chain_i
);

  pts_pkg::state_e              state_q, state_d;
  pts_pkg::req_t                req_q;
  logic [pts_pkg::TOTAL_W-1:0]  total_q, total_d;
  logic [pts_pkg::IDX_W-1:0]    cur_q, cur_d;
  logic [TICK_BITS-1:0]         ticks_q, ticks_d;
  logic [63:0]                  ticks_wide;
  pts_pkg::res_t                res_q, res_d;
  logic                         done_q, done_d;
  logic                         dispatch;
  logic                         accept;

  assign busy       = (state_q != pts_pkg::S_IDLE);
  assign accept     = start && !busy;
  assign wait_o     = TICK_BITS'(req_q.delay_ticks);
  assign ticks_wide = 64'(ticks_d);

  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    cur_d    = cur_q;
    ticks_d  = ticks_q;
    res_d    = res_q;
    done_d   = 1'b0;
    dispatch = 1'b0;
    cmd_o    = '{op: pts_pkg::CELL_NOP, idx: '0, prio: req_q.new_priority,
                 auto_start: req_q.auto_start, total: total_q};
    chain_o  = '{go: 1'b0, best: '0, pick: pts_pkg::IDX_W'(total_q - 1'b1)};
    unique case (state_q)
      pts_pkg::S_IDLE: begin
        if (accept) state_d = pts_pkg::S_EXEC;
      end
      pts_pkg::S_EXEC: begin
        res_d.status       = pts_pkg::STAT_OK;
        res_d.new_handle   = '0;
        res_d.running_task = cur_q;
        res_d.switched     = 1'b0;
        unique case (pts_pkg::req_e'(req_q.req_type))
          pts_pkg::REQ_CREATE: begin
            if (total_q < pts_pkg::TOTAL_W'(pts_pkg::MAX_TASKS)) begin
              cmd_o.op         = pts_pkg::CELL_CREATE;
              cmd_o.idx        = total_q[pts_pkg::IDX_W-1:0];
              res_d.new_handle = total_q[pts_pkg::IDX_W-1:0];
              total_d          = total_q + 1'b1;
            end else begin
              res_d.status = pts_pkg::STAT_FULL;
            end
          end
          pts_pkg::REQ_DELAY, pts_pkg::REQ_SUSPEND: begin
            if (total_q == '0) begin
              res_d.status = pts_pkg::STAT_NO_TASKS;
            end else begin
              cmd_o.op  = (pts_pkg::req_e'(req_q.req_type) == pts_pkg::REQ_DELAY) ?
                          pts_pkg::CELL_WAIT : pts_pkg::CELL_SUSPEND;
              cmd_o.idx = cur_q;
              dispatch  = 1'b1;
            end
          end
          pts_pkg::REQ_ACTIVATE: begin
            if (total_q == '0) begin
              res_d.status = pts_pkg::STAT_NO_TASKS;
            end else if (pts_pkg::TOTAL_W'(req_q.target_task) >= total_q) begin
              res_d.status = pts_pkg::STAT_BAD_IDX;
            end else begin
              cmd_o.op  = pts_pkg::CELL_READY;
              cmd_o.idx = req_q.target_task;
              dispatch  = 1'b1;
            end
          end
          pts_pkg::REQ_TICK: begin
            ticks_d = ticks_q + TICK_BITS'(1);
            if (total_q == '0) begin
              res_d.status = pts_pkg::STAT_NO_TASKS;
            end else begin
              cmd_o.op = pts_pkg::CELL_TICK;
              dispatch = 1'b1;
            end
          end
          default: begin
          end
        endcase
        res_d.tick_now = ticks_wide[31:0];
        if (dispatch) begin
          state_d = pts_pkg::S_LAUNCH;
        end else begin
          state_d = pts_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end
      pts_pkg::S_LAUNCH: begin
        // The sweep starts in the cycle after the cells took the update.
        chain_o.go = 1'b1;
        state_d    = pts_pkg::S_SCAN;
      end
      pts_pkg::S_SCAN: begin
        if (chain_i.go) begin
          if (chain_i.pick != cur_q) begin
            cur_d              = chain_i.pick;
            cmd_o.op           = pts_pkg::CELL_RUN;
            cmd_o.idx          = chain_i.pick;
            res_d.switched     = 1'b1;
            res_d.running_task = chain_i.pick;
          end
          state_d = pts_pkg::S_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        state_d = pts_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pts_pkg::S_IDLE;
      total_q <= '0;
      cur_q   <= '0;
      ticks_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      cur_q   <= cur_d;
      ticks_q <= ticks_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= req_i;
    res_q <= res_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

[sv/priority_task_scheduler_top.sv]
// Top level of the priority task scheduler: sequencer and a chain of task cells.
//
//   channel   ports                  handshake
//   request   start, req_i, busy     taken when start is high and busy is low
//   result    done_o, res_o          one-cycle strobe, always taken
//
// Create and any request that needs no dispatch return their result from the
// execute state. A dispatching request then runs the launch and scan states:
// the search walks the cell chain one cell a cycle.
// Reset clears the task count, current task and tick count; entries are
// written by create before use. The receiver cannot stall; busy holds off
// the next item until the result is out.
module priority_task_scheduler_top #(
  parameter int unsigned TICK_BITS = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  pts_pkg::req_t   req_i,
  output logic            done_o,
  output pts_pkg::res_t   res_o
);

  pts_pkg::cell_cmd_t   cmd;
  logic [TICK_BITS-1:0] wait_val;
  pts_pkg::chain_t      chain [pts_pkg::MAX_TASKS+1];

  pts_ctrl #(
    .TICK_BITS(TICK_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o),
    .cmd_o  (cmd),
    .wait_o (wait_val),
    .chain_o(chain[0]),
    .chain_i(chain[pts_pkg::MAX_TASKS])
  );

  for (genvar g = 0; g < pts_pkg::MAX_TASKS; g++) begin : g_cell
    pts_cell #(
      .TICK_BITS(TICK_BITS),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .wait_i (wait_val),
      .chain_i(chain[g]),
      .chain_o(chain[g+1])
    );
  end

`ifndef SYNTHESIS
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe lasted more than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after taking an item");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[pts_pkg::MAX_TASKS].go |-> busy)
    else $error("dispatch sweep finished while idle");
`endif

endmodule

[tb/sv/tb_priority_task_scheduler_top.sv]
// Self-checking testbench of the priority task scheduler with a task table scoreboard.
`timescale 1ns / 1ps

module tb_priority_task_scheduler_top;

  localparam logic [2:0] REQ_SPARE_LO = 3'd5;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;
  localparam int unsigned RANDOM_ITEMS = 1250;

  // Mirror of the task table; predicts each result and checks it.
  class task_table_model;
    pts_pkg::mode_e  mode_tab [pts_pkg::MAX_TASKS];
    logic [7:0]      prio_tab [pts_pkg::MAX_TASKS];
    logic [31:0]     wait_tab [pts_pkg::MAX_TASKS];
    int unsigned     total;
    int unsigned     cur_idx;
    logic [31:0]     ticks;
    pts_pkg::res_t   expected_res_q[$];
    int unsigned     mismatch_count;

    function new();
      for (int i = 0; i < pts_pkg::MAX_TASKS; i++) begin
        mode_tab[i] = pts_pkg::MODE_READY;
        prio_tab[i] = '0;
        wait_tab[i] = '0;
      end
      total = 0;
      cur_idx = 0;
      ticks = '0;
      mismatch_count = 0;
    endfunction

    // Highest nonzero priority among ready or running tasks, else the newest task.
    function bit dispatch();
      int unsigned pick;
      logic [7:0] best;
      pick = total - 1;
      best = '0;
      for (int i = 0; i < total; i++) begin
        if (prio_tab[i] > best && (mode_tab[i] == pts_pkg::MODE_RUNNING ||
                                   mode_tab[i] == pts_pkg::MODE_READY)) begin
          best = prio_tab[i];
          pick = i;
        end
      end
      if (pick != cur_idx) begin
        cur_idx = pick;
        mode_tab[pick] = pts_pkg::MODE_RUNNING;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(pts_pkg::req_t r);
      pts_pkg::res_t e;
      e = '0;
      e.status = pts_pkg::STAT_OK;
      case (r.req_type)
        pts_pkg::REQ_CREATE: begin
          if (total < pts_pkg::MAX_TASKS) begin
            mode_tab[total] = r.auto_start ? pts_pkg::MODE_READY : pts_pkg::MODE_SUSPENDED;
            prio_tab[total] = r.new_priority;
            wait_tab[total] = '0;
            e.new_handle = pts_pkg::IDX_W'(total);
            total++;
          end else begin
            e.status = pts_pkg::STAT_FULL;
          end
        end
        pts_pkg::REQ_DELAY, pts_pkg::REQ_SUSPEND: begin
          if (total == 0) begin
            e.status = pts_pkg::STAT_NO_TASKS;
          end else begin
            if (r.req_type == pts_pkg::REQ_DELAY) begin
              mode_tab[cur_idx] = pts_pkg::MODE_WAITING;
              wait_tab[cur_idx] = r.delay_ticks;
            end else begin
              mode_tab[cur_idx] = pts_pkg::MODE_SUSPENDED;
            end
            e.switched = dispatch();
          end
        end
        pts_pkg::REQ_ACTIVATE: begin
          if (total == 0) begin
            e.status = pts_pkg::STAT_NO_TASKS;
          end else if (r.target_task >= total) begin
            e.status = pts_pkg::STAT_BAD_IDX;
          end else begin
            mode_tab[r.target_task] = pts_pkg::MODE_READY;
            e.switched = dispatch();
          end
        end
        pts_pkg::REQ_TICK: begin
          ticks = ticks + 32'd1;
          if (total == 0) begin
            e.status = pts_pkg::STAT_NO_TASKS;
          end else begin
            for (int i = 0; i < total; i++) begin
              if (mode_tab[i] == pts_pkg::MODE_WAITING) begin
                wait_tab[i] = wait_tab[i] - 32'd1;
                if (wait_tab[i] == '0) mode_tab[i] = pts_pkg::MODE_READY;
              end
            end
            e.switched = dispatch();
          end
        end
        default: ;
      endcase
      e.running_task = pts_pkg::IDX_W'(cur_idx);
      e.tick_now = ticks;
      expected_res_q.push_back(e);
    endfunction

    function void compare_field(string name, logic [31:0] exp_val, logic [31:0] got_val);
      if (exp_val !== got_val) begin
        $error("%s: expected %0d, got %0d", name, exp_val, got_val);
        mismatch_count++;
      end
    endfunction

    function void check_result(pts_pkg::res_t got);
      pts_pkg::res_t e;
      if (expected_res_q.size() == 0) begin
        $error("result with no item pending: status %0d tick_now %0d", got.status, got.tick_now);
        mismatch_count++;
        return;
      end
      e = expected_res_q.pop_front();
      compare_field("status", 32'(e.status), 32'(got.status));
      compare_field("new_handle", 32'(e.new_handle), 32'(got.new_handle));
      compare_field("running_task", 32'(e.running_task), 32'(got.running_task));
      compare_field("switched", 32'(e.switched), 32'(got.switched));
      compare_field("tick_now", e.tick_now, got.tick_now);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  pts_pkg::req_t req_i;
  logic          done_o;
  pts_pkg::res_t res_o;

  task_table_model table_model;

  priority_task_scheduler_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) table_model.note_request(req_i);
      if (done_o) table_model.check_result(res_o);
    end
  end

  function automatic pts_pkg::req_t mk_req(logic [2:0] kind, logic [7:0] prio, logic auto,
                                           logic [31:0] delay, logic [2:0] target);
    pts_pkg::req_t r;
    r.req_type     = kind;
    r.new_priority = prio;
    r.auto_start   = auto;
    r.delay_ticks  = delay;
    r.target_task  = target;
    return r;
  endfunction

  // Mostly valid requests with short delays, so that waiting tasks come back.
  function automatic pts_pkg::req_t rand_request();
    pts_pkg::req_t r;
    int unsigned w;
    int unsigned d;
    r.new_priority = 8'($urandom_range(0, 255));
    r.auto_start   = 1'($urandom_range(0, 1));
    d = $urandom_range(0, 9);
    if (d == 0) r.delay_ticks = '0;
    else if (d == 1) r.delay_ticks = $urandom();
    else if (d == 2) r.delay_ticks = '1;
    else r.delay_ticks = 32'($urandom_range(1, 6));
    if (table_model.total > 0 && $urandom_range(0, 4) != 0)
      r.target_task = 3'($urandom_range(0, table_model.total - 1));
    else
      r.target_task = 3'($urandom_range(0, 7));
    w = $urandom_range(0, 99);
    if (w < 4) r.req_type = pts_pkg::REQ_CREATE;
    else if (w < 20) r.req_type = pts_pkg::REQ_DELAY;
    else if (w < 30) r.req_type = pts_pkg::REQ_SUSPEND;
    else if (w < 55) r.req_type = pts_pkg::REQ_ACTIVATE;
    else if (w < 95) r.req_type = pts_pkg::REQ_TICK;
    else r.req_type = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
    return r;
  endfunction

  task automatic send_item(input pts_pkg::req_t r);
    @(negedge clk_i);
    start = 1'b1;
    req_i = r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start = 1'b0;
      req_i = rand_request();
    end
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start = 1'b0;
    while (table_model.expected_res_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    #(10_000_000);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned sent;
    int unsigned burst;
    pts_pkg::req_t r;
    table_model = new();
    start = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    idle_for(2);

    // Empty table: every request but create reports no tasks; spare codes do nothing.
    send_item(mk_req(pts_pkg::REQ_TICK, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_DELAY, 8'd0, 1'b0, 32'd5, 3'd0));
    send_item(mk_req(pts_pkg::REQ_SUSPEND, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_ACTIVATE, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(REQ_SPARE_LO, 8'd255, 1'b1, 32'hFFFF_FFFF, 3'd7));
    send_item(mk_req(REQ_SPARE_HI, 8'd0, 1'b0, 32'd0, 3'd0));
    // A zero-priority task is only ever chosen by the fallback.
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd0, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_TICK, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd200, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd255, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_ACTIVATE, 8'd0, 1'b0, 32'd0, 3'd7));
    send_item(mk_req(pts_pkg::REQ_ACTIVATE, 8'd0, 1'b0, 32'd0, 3'd3));
    send_item(mk_req(pts_pkg::REQ_TICK, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_ACTIVATE, 8'd0, 1'b0, 32'd0, 3'd2));
    send_item(mk_req(pts_pkg::REQ_DELAY, 8'd0, 1'b0, 32'd1, 3'd0));
    send_item(mk_req(pts_pkg::REQ_TICK, 8'd0, 1'b0, 32'd0, 3'd0));
    // Delay zero wraps: the task waits the full tick range.
    send_item(mk_req(pts_pkg::REQ_DELAY, 8'd0, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd200, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_SUSPEND, 8'd0, 1'b0, 32'd0, 3'd0));
    // Equal priorities: the lower index wins.
    send_item(mk_req(pts_pkg::REQ_ACTIVATE, 8'd0, 1'b0, 32'd0, 3'd1));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd1, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd128, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd255, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd17, 1'b0, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_CREATE, 8'd99, 1'b1, 32'd0, 3'd0));
    send_item(mk_req(pts_pkg::REQ_DELAY, 8'd0, 1'b0, 32'hFFFF_FFFF, 3'd0));
    wait_all_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      repeat (burst) begin
        r = rand_request();
        send_item(r);
        if (r.req_type < REQ_SPARE_LO) sent++;
      end
      if (sent % 300 < burst) wait_all_results();
      else if ($urandom_range(0, 9) < 3) idle_for(0);
      else idle_for($urandom_range(1, 14));
    end

    wait_all_results();
    repeat (pts_pkg::MAX_TASKS + 8) @(posedge clk_i);
    if (table_model.mismatch_count == 0 && table_model.expected_res_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
sv/pts_pkg.sv
sv/pts_cell.sv
sv/pts_ctrl.sv
sv/priority_task_scheduler_top.sv
tb/sv/tb_priority_task_scheduler_top.sv
